// File: sv/salc_pkg.sv
// Shared constants and types of the set-associative LRU tag store.
`default_nettype none

package salc_pkg;

  localparam int MAX_SETS = 256;
  localparam int MAX_WAYS = 8;

  localparam int SB_LIMIT  = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_IDX_W = (SB_LIMIT > 0) ? SB_LIMIT : 1;
  localparam int NUM_ROWS  = 1 << SET_IDX_W;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TREE_N    = 1 << WAY_W;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam logic [1:0] REQ_MODIFY = 2'd0;

  localparam logic [3:0] SET_BITS_RST   = 4'd4;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  localparam int RESULT_W = 2 + 1 + 1 + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef struct packed {
    logic                 modify;
    logic [SET_IDX_W-1:0] set;
    logic [TAG_W-1:0]     tag;
    logic [MAX_WAYS-1:0]  way_en;
  } req_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]              valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
  } row_t;

  typedef struct packed {
    logic [CNT_W-1:0] evict_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] hit_total;
    logic             evicted;
    logic             missed;
    logic [1:0]       hits_added;
  } result_t;

endpackage

`default_nettype wire

// File: sv/salc_front.sv
// Configuration registers and request decode into set index, tag and way enables.
`default_nettype none

module salc_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [salc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [salc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [salc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [salc_pkg::ADDR_W-1:0]      in_tdata,
  input  wire  [1:0]                       in_tuser,
  input  wire                              q_full,
  output logic                             q_push,
  output salc_pkg::req_t                   q_wdata
);
  import salc_pkg::*;

  logic [3:0] set_bits_r;
  logic [5:0] block_bits_r;
  logic [3:0] ways_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic [3:0] sb;
  logic [3:0] wc;
  logic [6:0] shamt;
  logic [ADDR_W-1:0] blk;
  logic [SET_IDX_W-1:0] set_mask;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_SET_BITS) begin
        set_bits_r <= cfg_pwdata[3:0];
      end
      if (cfg_idx == REG_BLOCK_BITS) begin
        block_bits_r <= cfg_pwdata[5:0];
      end
      if (cfg_idx == REG_WAYS) begin
        ways_r <= cfg_pwdata[3:0];
      end
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SET_BITS:   cfg_prdata = {28'd0, set_bits_r};
      REG_BLOCK_BITS: cfg_prdata = {26'd0, block_bits_r};
      REG_WAYS:       cfg_prdata = {28'd0, ways_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (32'(set_bits_r) > SB_LIMIT) begin
      sb = 4'(SB_LIMIT);
    end else begin
      sb = set_bits_r;
    end
    if (ways_r == 4'd0) begin
      wc = 4'd1;
    end else if (32'(ways_r) > MAX_WAYS) begin
      wc = 4'(MAX_WAYS);
    end else begin
      wc = ways_r;
    end
    shamt    = {1'b0, block_bits_r} + {3'b000, sb};
    blk      = in_tdata >> block_bits_r;
    set_mask = ~({SET_IDX_W{1'b1}} << sb);
    q_wdata.modify = (in_tuser == REQ_MODIFY);
    q_wdata.set    = blk[SET_IDX_W-1:0] & set_mask;
    q_wdata.tag    = in_tdata >> shamt;
    for (int w = 0; w < MAX_WAYS; w++) begin
      q_wdata.way_en[w] = (w < int'(wc));
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

endmodule

`default_nettype wire

// File: sv/salc_fifo.sv
// Short request queue between the decode front and the tag store back end.
`default_nettype none

module salc_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  salc_pkg::req_t  wdata,
  output logic            full,
  input  wire             pop,
  output logic            rvalid,
  output salc_pkg::req_t  rdata
);
  import salc_pkg::*;

  req_t            ent_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wp_r;
  logic [QP_W-1:0] rp_r;
  logic [QP_W:0]   cnt_r;

  assign full   = (32'(cnt_r) == QUEUE_DEPTH);
  assign rvalid = (cnt_r != '0);
  assign rdata  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (32'(wp_r) == QUEUE_DEPTH - 1) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (32'(rp_r) == QUEUE_DEPTH - 1) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/salc_back.sv
// Set row read, hit and LRU victim selection, row write-back and running counters.
`default_nettype none

module salc_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_valid,
  input  salc_pkg::req_t    q_rdata,
  output logic              q_pop,
  output logic              res_valid,
  input  wire               res_ready,
  output salc_pkg::result_t res
);
  import salc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  row_t                 mem [NUM_ROWS];
  logic [NUM_ROWS-1:0]  row_init_r;
  row_t                 rd_r;
  logic                 rd_init_r;
  row_t                 row;
  row_t                 new_row;

  logic [1:0]           st_r;
  req_t                 cur_r;
  logic [STAMP_W-1:0]   clk_r;
  logic [STAMP_W-1:0]   new_clk;
  logic [CNT_W-1:0]     hit_cnt_r;
  logic [CNT_W-1:0]     miss_cnt_r;
  logic [CNT_W-1:0]     ev_cnt_r;

  logic                 hit;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     victim;
  logic                 hit_r;
  logic [WAY_W-1:0]     hit_way_r;
  logic [WAY_W-1:0]     victim_r;
  logic                 vic_valid_r;
  logic [WAY_W-1:0]     wr_way;
  logic [1:0]           add;
  logic                 miss;
  logic                 ev;
  logic                 wr_en;
  logic                 out_valid_r;
  result_t              res_r;

  logic [MAX_WAYS-1:0]  match;
  logic [STAMP_W-1:0]   t_st  [WAY_W+1][TREE_N];
  logic [WAY_W-1:0]     t_idx [WAY_W+1][TREE_N];
  logic                 t_en  [WAY_W+1][TREE_N];

  assign q_pop = q_valid && (st_r == ST_IDLE);
  assign row   = rd_init_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_r.set] <= new_row;
    end
    if (q_pop) begin
      rd_r      <= mem[q_rdata.set];
      rd_init_r <= row_init_r[q_rdata.set];
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      match[w] = cur_r.way_en[w] && row.valid[w] && (row.tag[w] == cur_r.tag);
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    for (int l = 0; l <= WAY_W; l++) begin
      for (int i = 0; i < TREE_N; i++) begin
        t_st[l][i]  = '0;
        t_idx[l][i] = WAY_W'(i);
        t_en[l][i]  = 1'b0;
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      t_st[0][i] = row.stamp[i];
      t_en[0][i] = cur_r.way_en[i];
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
        if (t_en[l][2*i] && (!t_en[l][2*i+1] || t_st[l][2*i] <= t_st[l][2*i+1])) begin
          t_st[l+1][i]  = t_st[l][2*i];
          t_idx[l+1][i] = t_idx[l][2*i];
          t_en[l+1][i]  = t_en[l][2*i];
        end else begin
          t_st[l+1][i]  = t_st[l][2*i+1];
          t_idx[l+1][i] = t_idx[l][2*i+1];
          t_en[l+1][i]  = t_en[l][2*i+1];
        end
      end
    end
    victim = t_idx[WAY_W][0];
  end

  always_comb begin
    wr_way  = hit_r ? hit_way_r : victim_r;
    new_clk = clk_r + 1'b1;
    new_row = row;
    new_row.valid[wr_way] = 1'b1;
    new_row.tag[wr_way]   = cur_r.tag;
    new_row.stamp[wr_way] = new_clk;
    miss = !hit_r;
    ev   = !hit_r && vic_valid_r;
    if (hit_r) begin
      add = cur_r.modify ? 2'd2 : 2'd1;
    end else begin
      add = cur_r.modify ? 2'd1 : 2'd0;
    end
  end

  assign wr_en = (st_r == ST_WRITE) && (!out_valid_r || res_ready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (st_r == ST_EVAL) begin
      hit_r       <= hit;
      hit_way_r   <= hit_way;
      victim_r    <= victim;
      vic_valid_r <= row.valid[victim];
    end
    if (wr_en) begin
      res_r.hits_added  <= add;
      res_r.missed      <= miss;
      res_r.evicted     <= ev;
      res_r.hit_total   <= hit_cnt_r + CNT_W'(add);
      res_r.miss_total  <= miss_cnt_r + CNT_W'(miss);
      res_r.evict_total <= ev_cnt_r + CNT_W'(ev);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      row_init_r  <= '0;
      clk_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      ev_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            st_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          st_r <= ST_WRITE;
        end
        ST_WRITE: begin
          if (wr_en) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
      if (wr_en) begin
        row_init_r[cur_r.set] <= 1'b1;
        clk_r       <= new_clk;
        hit_cnt_r   <= hit_cnt_r + CNT_W'(add);
        miss_cnt_r  <= miss_cnt_r + CNT_W'(miss);
        ev_cnt_r    <= ev_cnt_r + CNT_W'(ev);
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

  a_evict_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!res_r.evicted || res_r.missed))
    else $error("eviction reported on a hit");

  a_hits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.hits_added != 2'd3))
    else $error("hit increment out of range");

  a_write_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (out_valid_r && (st_r == ST_IDLE)))
    else $error("write-back did not present a result");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == ST_EVAL))
    else $error("request popped outside idle");

endmodule

`default_nettype wire

// File: sv/set_assoc_lru_cache_tag_model_core.sv
// Top level of the set-associative LRU cache tag store with hit, miss and eviction counters.
// Each access word is decoded into set, tag and way enables on entry and queued (two deep);
// the back end reads the whole set row from a single-port row memory, picks the hit way
// or the least-recently-stamped victim in its evaluate state, and writes the row back while
// loading the result register in its write state. A new word is taken only once the last
// is written back; the queue and the result register let input and output stall
// independently. Rows carry a written flag cleared at reset, so no clearing pass is needed
// after reset. Configuration must be written through the APB-style port while the block is
// idle, which it does not enforce; stored lines are kept and read under the new geometry.
`default_nettype none

module set_assoc_lru_cache_tag_model_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_psel,
  input  wire                                  cfg_penable,
  input  wire                                  cfg_pwrite,
  input  wire  [salc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire  [salc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [salc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // address[63:0]
  input  wire  [salc_pkg::ADDR_W-1:0]          in_tdata,
  // req_type[1:0]
  input  wire  [1:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // hits_added[1:0], missed[2], evicted[3], hit_total[35:4], miss_total[67:36],
  // evict_total[99:68], zero padding above
  output logic [salc_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import salc_pkg::*;

  req_t    push_data;
  req_t    pop_data;
  logic    push;
  logic    full;
  logic    pop;
  logic    q_valid;
  result_t res;

  salc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_full      (full),
    .q_push      (push),
    .q_wdata     (push_data)
  );

  salc_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (push_data),
    .full   (full),
    .pop    (pop),
    .rvalid (q_valid),
    .rdata  (pop_data)
  );

  salc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (pop_data),
    .q_pop     (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the set-associative LRU cache tag store and its counters.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int NUM_LINES   = MAX_SETS * MAX_WAYS;
  localparam int NUM_PHASES  = 11;
  localparam int PHASE_ITEMS = 160;
  localparam int TAG_POOL    = 10;

  typedef struct {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
  } access_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [ADDR_W-1:0]      in_tdata    = '0;
  logic [1:0]             in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Mirror of the configuration registers and of the tag store contents.
  logic [3:0]   set_bits_q   = SET_BITS_RST;
  logic [5:0]   block_bits_q = BLOCK_BITS_RST;
  logic [3:0]   ways_q       = WAYS_RST;
  logic         line_valid_q [NUM_LINES];
  logic [63:0]  line_tag_q   [NUM_LINES];
  logic [31:0]  line_stamp_q [NUM_LINES];
  logic [31:0]  stamp_clock  = '0;
  logic [31:0]  hit_sum      = '0;
  logic [31:0]  miss_sum     = '0;
  logic [31:0]  evict_sum    = '0;

  access_t pending_accesses [$];
  result_t expected_results [$];

  int   errors      = 0;
  int   phase_no    = -1;
  int   in_gap_max  = 15;
  int   out_gap_max = 15;
  int   in_wait     = 0;
  int   out_wait    = 0;
  logic out_hold    = 1'b0;
  logic in_fire     = 1'b0;
  logic out_fire    = 1'b0;

  int phase_cfg [NUM_PHASES][3] = '{
    '{0, 0, 1}, '{8, 32, 8}, '{15, 63, 15}, '{2, 5, 4}, '{3, 6, 0}, '{8, 0, 8},
    '{4, 62, 3}, '{6, 12, 5}, '{7, 56, 2}, '{8, 56, 7}, '{0, 32, 15}
  };

  set_assoc_lru_cache_tag_model_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void eff_geometry(output int unsigned sb, output int unsigned ways);
    sb = (set_bits_q > SB_LIMIT) ? SB_LIMIT : set_bits_q;
    if (ways_q == 0) begin
      ways = 1;
    end else if (ways_q > MAX_WAYS) begin
      ways = MAX_WAYS;
    end else begin
      ways = ways_q;
    end
  endfunction

  function automatic result_t predict_access(input logic [1:0] kind,
                                             input logic [ADDR_W-1:0] addr);
    int unsigned sb, ways, base, victim;
    logic [63:0] blk, tag;
    logic [31:0] best;
    logic        hit;
    result_t     r;
    eff_geometry(sb, ways);
    blk = addr >> block_bits_q;
    base = int'(blk & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
    tag = (block_bits_q + sb >= 64) ? 64'd0 : blk >> sb;
    stamp_clock = stamp_clock + 32'd1;
    r = '0;
    hit = 1'b0;
    for (int w = 0; w < ways; w++) begin
      if (!hit && line_valid_q[base + w] && line_tag_q[base + w] == tag) begin
        line_stamp_q[base + w] = stamp_clock;
        r.hits_added = (kind == REQ_MODIFY) ? 2'd2 : 2'd1;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      victim = 0;
      best = line_stamp_q[base];
      for (int w = 1; w < ways; w++) begin
        if (line_stamp_q[base + w] < best) begin
          best = line_stamp_q[base + w];
          victim = w;
        end
      end
      r.missed = 1'b1;
      r.evicted = line_valid_q[base + victim];
      if (kind == REQ_MODIFY) begin
        r.hits_added = 2'd1;
      end
      line_valid_q[base + victim] = 1'b1;
      line_tag_q[base + victim] = tag;
      line_stamp_q[base + victim] = stamp_clock;
    end
    hit_sum = hit_sum + r.hits_added;
    miss_sum = miss_sum + r.missed;
    evict_sum = evict_sum + r.evicted;
    r.hit_total = hit_sum;
    r.miss_total = miss_sum;
    r.evict_total = evict_sum;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_SET_BITS:   set_bits_q = value[3:0];
      REG_BLOCK_BITS: block_bits_q = value[5:0];
      REG_WAYS:       ways_q = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_accesses.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Both channels are sampled here so that expectations are queued in acceptance order.
  always @(posedge clk) begin
    result_t got, want;
    in_fire <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(predict_access(in_tuser, in_tdata));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[RESULT_W-1:0]);
      if (expected_results.size() == 0) begin
        $error("result word arrived with no access outstanding");
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("hits_added", want.hits_added, got.hits_added);
        check_field("missed", want.missed, got.missed);
        check_field("evicted", want.evicted, got.evicted);
        check_field("hit_total", want.hit_total, got.hit_total);
        check_field("miss_total", want.miss_total, got.miss_total);
        check_field("evict_total", want.evict_total, got.evict_total);
      end
    end
  end

  always @(negedge clk) begin
    access_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_fire || !in_tvalid) begin
      if (in_fire) begin
        in_wait = $urandom_range(0, in_gap_max);
      end
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (pending_accesses.size() > 0) begin
        item = pending_accesses.pop_front();
        in_tdata <= item.addr;
        in_tuser <= item.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_fire) begin
        out_wait = $urandom_range(0, out_gap_max);
      end
      if (out_hold) begin
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // A long receiver stall while the sender keeps offering words back to back.
  initial begin
    wait (phase_no == 3);
    repeat (40) @(negedge clk);
    out_hold <= 1'b1;
    repeat (400) @(negedge clk);
    out_hold <= 1'b0;
  end

  initial begin
    access_t     a;
    int unsigned sb, ways;
    logic [63:0] tags [TAG_POOL];
    logic [63:0] set, off;
    logic [31:0] junk;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_valid_q[i] = 1'b0;
      line_tag_q[i] = '0;
      line_stamp_q[i] = '0;
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    pending_accesses.push_back('{REQ_MODIFY, 64'h0});
    pending_accesses.push_back('{REQ_MODIFY, 64'h0});
    pending_accesses.push_back('{REQ_LOAD, 64'h8});
    pending_accesses.push_back('{REQ_STORE, 64'hF});
    pending_accesses.push_back('{REQ_SPARE, 64'h0});
    pending_accesses.push_back('{REQ_LOAD, 64'h100});
    pending_accesses.push_back('{REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_accesses.push_back('{REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_accesses.push_back('{REQ_MODIFY, 64'h8000_0000_0000_0000});
    pending_accesses.push_back('{REQ_SPARE, 64'h7FFF_FFFF_FFFF_FFF0});
    pending_accesses.push_back('{REQ_MODIFY, 64'h0});
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_no = p;
      junk = $urandom;
      apb_write(REG_SET_BITS, {junk[31:4], 4'(phase_cfg[p][0])});
      junk = $urandom;
      apb_write(REG_BLOCK_BITS, {junk[31:6], 6'(phase_cfg[p][1])});
      junk = $urandom;
      apb_write(REG_WAYS, {junk[31:4], 4'(phase_cfg[p][2])});
      if (p == 5) begin
        apb_write(REG_SPARE, $urandom);
      end
      in_gap_max = (p % 2 == 1) ? 0 : 15;
      out_gap_max = (p % 2 == 1) ? 0 : 15;
      eff_geometry(sb, ways);
      for (int j = 0; j < TAG_POOL; j++) begin
        tags[j] = {$urandom, $urandom};
      end
      repeat (PHASE_ITEMS) begin
        a.kind = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 15) == 0) begin
          a.addr = {$urandom, $urandom};
        end else begin
          set = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
          set = set & ((64'd1 << sb) - 64'd1);
          off = {$urandom, $urandom} & ((64'd1 << block_bits_q) - 64'd1);
          a.addr = (tags[$urandom_range(0, ways + 1)] << (sb + block_bits_q))
                   | (set << block_bits_q) | off;
        end
        pending_accesses.push_back(a);
      end
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/salc_pkg.sv
sv/salc_front.sv
sv/salc_fifo.sv
sv/salc_back.sv
sv/set_assoc_lru_cache_tag_model_core.sv
tb/tb_top.sv
